### sv/gfca_pkg.sv
// Shared types and constants for the grid field cell average gather unit.
package gfca_pkg;

	localparam int COORD_W   = 32;
	localparam int ADDR_W    = 16;
	localparam int STORE_DEPTH = 2 ** ADDR_W;
	localparam int VAL_W     = 32;
	localparam int DIM_W     = 10;
	localparam int IDX_W     = 11;
	localparam int CNT_W     = 5;
	localparam int COMP_W    = 4;
	localparam int SUM_W     = VAL_W + 3;
	localparam int MAX_COMPONENTS = 16;

	localparam logic [2:0] REG_ORIGIN_X   = 3'd0;
	localparam logic [2:0] REG_ORIGIN_Y   = 3'd1;
	localparam logic [2:0] REG_ORIGIN_Z   = 3'd2;
	localparam logic [2:0] REG_INV_CELL   = 3'd3;
	localparam logic [2:0] REG_INV_TIME   = 3'd4;
	localparam logic [2:0] REG_GRID_DIMS  = 3'd5;
	localparam logic [2:0] REG_TIME_STEPS = 3'd6;
	localparam logic [2:0] REG_COMP_COUNT = 3'd7;

	typedef enum logic [1:0] {
		CMD_WRITE,
		CMD_QUERY,
		CMD_OOB
	} cmd_kind_t;

	// one queued command: a store write, an in-bounds query or a miss
	typedef struct packed {
		cmd_kind_t          kind;
		logic [ADDR_W-1:0]  addr;   // write address, or address of corner 0
		logic [VAL_W-1:0]   value;
		logic [ADDR_W-1:0]  ay;     // address step for y + 1
		logic [ADDR_W-1:0]  az;     // address step for z + 1
		logic [CNT_W-1:0]   cnt;    // clamped count, also the x + 1 step
	} cmd_t;

	typedef struct packed {
		logic signed [COORD_W-1:0] origin_x;
		logic signed [COORD_W-1:0] origin_y;
		logic signed [COORD_W-1:0] origin_z;
		logic [31:0]               inv_cell;
		logic [31:0]               inv_time;
		logic [DIM_W-1:0]          nx;
		logic [DIM_W-1:0]          ny;
		logic [DIM_W-1:0]          nz;
		logic [IDX_W-1:0]          time_steps;
		logic [CNT_W-1:0]          cnt;  // already clamped to 1..MAX_COMPONENTS
	} cfg_t;

endpackage

### sv/gfca_front.sv
// Front end: accepts beats, floors the query to cell indices, builds addresses.
module gfca_front import gfca_pkg::*; (
	input  logic                 clk,
	input  logic                 arst_n,
	input  cfg_t                 cfg,
	input  logic                 in_valid,
	output logic                 in_ready,
	input  logic                 in_op,
	input  logic [ADDR_W-1:0]    in_addr,
	input  logic [VAL_W-1:0]     in_value,
	input  logic [COORD_W-1:0]   in_t,
	input  logic [COORD_W-1:0]   in_x,
	input  logic [COORD_W-1:0]   in_y,
	input  logic [COORD_W-1:0]   in_z,
	output logic                 push,
	output cmd_t                 push_cmd,
	input  logic                 q_full
);

	typedef enum logic [2:0] {
		F_IDLE,
		F_MUL,
		F_CHK,
		F_ADR,
		F_PUSH
	} fstate_t;

	fstate_t              state_q;
	logic [1:0]           ax_q;
	logic [2:0]           step_q;
	logic                 ok_q;
	logic                 neg_q;
	logic [63:0]          prod_q;
	logic                 op_q;
	logic [ADDR_W-1:0]    addr_q;
	logic [VAL_W-1:0]     value_q;
	logic [COORD_W-1:0]   pos_q [4];
	logic [IDX_W-1:0]     idx_q [4];
	logic [ADDR_W-1:0]    acc_q;
	logic [ADDR_W-1:0]    a0_q;
	logic [ADDR_W-1:0]    ay_q;
	logic [ADDR_W-1:0]    az_q;

	logic signed [COORD_W:0] diff;
	logic signed [COORD_W-1:0] org;
	logic [31:0]          inv;
	logic [31:0]          idx;
	logic [IDX_W-1:0]     limit;
	logic                 axis_ok;
	logic                 static_t;
	logic [ADDR_W-1:0]    ma, mb, mc, mres;

	assign static_t = (cfg.time_steps == IDX_W'(1));

	// axis 0 is time, 1..3 are x, y, z
	always_comb begin
		case (ax_q)
			2'd0: begin org = '0;           inv = cfg.inv_time; limit = cfg.time_steps; end
			2'd1: begin org = cfg.origin_x; inv = cfg.inv_cell;
				limit = (cfg.nx == '0) ? '0 : IDX_W'(cfg.nx - DIM_W'(1)); end
			2'd2: begin org = cfg.origin_y; inv = cfg.inv_cell;
				limit = (cfg.ny == '0) ? '0 : IDX_W'(cfg.ny - DIM_W'(1)); end
			default: begin org = cfg.origin_z; inv = cfg.inv_cell;
				limit = (cfg.nz == '0) ? '0 : IDX_W'(cfg.nz - DIM_W'(1)); end
		endcase
		diff = $signed({pos_q[ax_q][COORD_W-1], pos_q[ax_q]}) - $signed({org[COORD_W-1], org});
		idx = neg_q ? 32'd0 : prod_q[63:32];
		axis_ok = (neg_q ? (inv == 32'd0) : 1'b1) && (idx < {21'd0, limit});
		if ((ax_q == 2'd0) && static_t) begin
			axis_ok = 1'b1;
			idx = 32'd0;
		end
	end

	// one 16-bit multiply-add per address step, all modulo the store depth
	always_comb begin
		case (step_q)
			3'd0: begin ma = ADDR_W'(idx_q[0]); mb = ADDR_W'(cfg.nz); mc = ADDR_W'(idx_q[3]); end
			3'd1: begin ma = acc_q; mb = ADDR_W'(cfg.ny); mc = ADDR_W'(idx_q[2]); end
			3'd2: begin ma = acc_q; mb = ADDR_W'(cfg.nx); mc = ADDR_W'(idx_q[1]); end
			3'd3: begin ma = acc_q; mb = ADDR_W'(cfg.cnt); mc = '0; end
			3'd4: begin ma = ADDR_W'(cfg.nx); mb = ADDR_W'(cfg.cnt); mc = '0; end
			3'd5: begin ma = ADDR_W'(cfg.nx); mb = ADDR_W'(cfg.ny); mc = '0; end
			default: begin ma = acc_q; mb = ADDR_W'(cfg.cnt); mc = '0; end
		endcase
		mres = ADDR_W'(ma * mb) + mc;
	end

	assign in_ready = (state_q == F_IDLE);
	assign push     = (state_q == F_PUSH) && !q_full;

	always_comb begin
		push_cmd       = '0;
		push_cmd.cnt   = cfg.cnt;
		push_cmd.value = value_q;
		push_cmd.ay    = ay_q;
		push_cmd.az    = az_q;
		if (!op_q) begin
			push_cmd.kind = CMD_WRITE;
			push_cmd.addr = addr_q;
		end else if (!ok_q) begin
			push_cmd.kind = CMD_OOB;
			push_cmd.addr = '0;
		end else begin
			push_cmd.kind = CMD_QUERY;
			push_cmd.addr = a0_q;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			F_IDLE: if (in_valid) begin
				op_q     <= in_op;
				addr_q   <= in_addr;
				value_q  <= in_value;
				pos_q[0] <= in_t;
				pos_q[1] <= in_x;
				pos_q[2] <= in_y;
				pos_q[3] <= in_z;
			end
			F_MUL: begin
				prod_q <= 64'(diff[31:0]) * 64'(inv);
				neg_q  <= diff[COORD_W];
			end
			F_CHK: idx_q[ax_q] <= idx[IDX_W-1:0];
			F_ADR: begin
				acc_q <= mres;
				if (step_q == 3'd3) a0_q <= mres;
				if (step_q == 3'd4) ay_q <= mres;
				if (step_q == 3'd6) az_q <= mres;
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= F_IDLE;
			ax_q    <= '0;
			step_q  <= '0;
			ok_q    <= 1'b0;
		end else begin
			case (state_q)
				F_IDLE: if (in_valid) begin
					ax_q    <= '0;
					step_q  <= '0;
					ok_q    <= 1'b1;
					state_q <= in_op ? F_MUL : F_PUSH;
				end
				F_MUL: state_q <= F_CHK;
				F_CHK: begin
					ok_q <= ok_q && axis_ok;
					if (ax_q == 2'd3)
						state_q <= (ok_q && axis_ok) ? F_ADR : F_PUSH;
					else begin
						ax_q    <= ax_q + 2'd1;
						state_q <= F_MUL;
					end
				end
				F_ADR: begin
					step_q <= step_q + 3'd1;
					if (step_q == 3'd6) state_q <= F_PUSH;
				end
				F_PUSH: if (!q_full) state_q <= F_IDLE;
				default: state_q <= F_IDLE;
			endcase
		end
	end

endmodule

### sv/gfca_queue.sv
// Two-entry command queue between front and back.
module gfca_queue import gfca_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic push,
	input  cmd_t push_cmd,
	output logic full,
	input  logic pop,
	output logic empty,
	output cmd_t head
);

	cmd_t       buf_q [2];
	logic       wp_q, rp_q;
	logic [1:0] cnt_q;

	assign full  = (cnt_q == 2'd2);
	assign empty = (cnt_q == 2'd0);
	assign head  = buf_q[rp_q];

	always_ff @(posedge clk) begin
		if (push) buf_q[wp_q] <= push_cmd;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wp_q  <= 1'b0;
			rp_q  <= 1'b0;
			cnt_q <= '0;
		end else begin
			if (push) wp_q <= ~wp_q;
			if (pop)  rp_q <= ~rp_q;
			case ({push, pop})
				2'b10:   cnt_q <= cnt_q + 2'd1;
				2'b01:   cnt_q <= cnt_q - 2'd1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

endmodule

### sv/gfca_back.sv
// Back end: field store, eight-corner gather per component, output register.
module gfca_back import gfca_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               q_empty,
	input  cmd_t               head,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [COMP_W-1:0]  out_comp,
	output logic [VAL_W-1:0]   out_value,
	output logic               out_last,
	output logic               out_oob
);

	typedef enum logic [1:0] {
		B_IDLE,
		B_RD,
		B_EMIT
	} bstate_t;

	logic [VAL_W-1:0]        mem [STORE_DEPTH];
	logic [VAL_W-1:0]        rdata_q;
	bstate_t                 state_q;
	logic [COMP_W-1:0]       comp_q;
	logic [3:0]              corner_q;
	logic                    rvalid_q;
	logic                    oob_q;
	logic signed [SUM_W-1:0] sum_q;
	logic signed [SUM_W-1:0] sum_next;
	logic [ADDR_W-1:0]       raddr;
	logic                    mem_we, mem_re;
	logic                    slot_free;
	logic                    is_last;

	assign slot_free = !out_valid || out_ready;
	assign is_last   = ({1'b0, comp_q} == head.cnt - CNT_W'(1));

	// corner bits: [2] x + 1, [1] y + 1, [0] z + 1
	assign raddr = head.addr
		+ (corner_q[2] ? ADDR_W'(head.cnt) : '0)
		+ (corner_q[1] ? head.ay : '0)
		+ (corner_q[0] ? head.az : '0)
		+ ADDR_W'(comp_q);

	assign mem_we = (state_q == B_IDLE) && !q_empty && (head.kind == CMD_WRITE);
	assign mem_re = (state_q == B_RD) && !corner_q[3];

	assign sum_next = rvalid_q ? sum_q + SUM_W'($signed(rdata_q)) : sum_q;

	assign pop = (state_q == B_IDLE && !q_empty && head.kind == CMD_WRITE)
		|| (state_q == B_EMIT && slot_free && (oob_q || is_last));

	always_ff @(posedge clk) begin
		if (mem_we)
			mem[head.addr] <= head.value;
		else if (mem_re)
			rdata_q <= mem[raddr];
	end

	always_ff @(posedge clk) begin
		if (state_q == B_EMIT && slot_free) begin
			out_comp  <= oob_q ? '0 : comp_q;
			out_value <= oob_q ? '0 : sum_q[SUM_W-1:3];
			out_last  <= oob_q || is_last;
			out_oob   <= oob_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q   <= B_IDLE;
			comp_q    <= '0;
			corner_q  <= '0;
			rvalid_q  <= 1'b0;
			oob_q     <= 1'b0;
			sum_q     <= '0;
			out_valid <= 1'b0;
		end else begin
			if (state_q == B_EMIT && slot_free)
				out_valid <= 1'b1;
			else if (out_ready)
				out_valid <= 1'b0;
			rvalid_q <= mem_re;
			case (state_q)
				B_IDLE: if (!q_empty) begin
					comp_q   <= '0;
					corner_q <= '0;
					case (head.kind)
						CMD_QUERY: begin
							oob_q   <= 1'b0;
							sum_q   <= '0;
							state_q <= B_RD;
						end
						CMD_OOB: begin
							oob_q   <= 1'b1;
							state_q <= B_EMIT;
						end
						default: state_q <= B_IDLE;
					endcase
				end
				B_RD: begin
					sum_q <= sum_next;
					if (!corner_q[3])
						corner_q <= corner_q + 4'd1;
					else
						state_q <= B_EMIT;
				end
				B_EMIT: if (slot_free) begin
					if (oob_q || is_last)
						state_q <= B_IDLE;
					else begin
						comp_q   <= comp_q + COMP_W'(1);
						corner_q <= '0;
						sum_q    <= '0;
						state_q  <= B_RD;
					end
				end
				default: state_q <= B_IDLE;
			endcase
		end
	end

endmodule

### sv/grid_field_cell_average_gather_unit.sv
// Top level of the grid field cell average gather unit.
// A tuser of 0 on an input beat writes one field store word; a tuser of 1 is a
// query. The query position minus the origin, and the time, are scaled by the
// reciprocal cell size and time step and floored to cell indices; each field
// component is then the average (floor of sum / 8) of the eight cell corners.
// One output beat per component comes out, tlast on the final one; a point
// outside the grid gives a single beat with tuser set and value zero. With a
// time_steps of 1 the time is ignored and slab 0 is used. The front end takes
// one beat at a time and does the index and address work for a query with one
// shared 32x32 multiplier, then a 16-bit multiply-add per step. The back end
// reads the single-port store once per corner of each component; a two-entry
// queue lets the front prepare the next item meanwhile. Store words that were
// never written read as undefined. Configuration is to be written by the user
// only while the unit is idle; the unit itself does not enforce this.
module grid_field_cell_average_gather_unit import gfca_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	output logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	output logic         s_axis_tready,
	// tdata: load_address[15:0], load_value[47:16], time_pos[79:48],
	// x_pos[111:80], y_pos[143:112], z_pos[175:144]
	input  logic [175:0] s_axis_tdata,
	// tuser: operation
	input  logic         s_axis_tuser,
	output logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	// tdata: component[3:0], field_value[35:4], zero fill [39:36]
	output logic [39:0]  m_axis_tdata,
	// tuser: out_of_bounds
	output logic         m_axis_tuser,
	output logic         m_axis_tlast
);

	cfg_t              cfg;
	logic [31:0]       org_x_q, org_y_q, org_z_q, inv_cell_q, inv_time_q;
	logic [29:0]       dims_q;
	logic [IDX_W-1:0]  tsteps_q;
	logic [CNT_W-1:0]  ccount_q;
	logic [CNT_W-1:0]  cnt_clamped;

	logic              push, q_full, q_empty, pop;
	cmd_t              push_cmd, head;
	logic [COMP_W-1:0] out_comp;
	logic [VAL_W-1:0]  out_value;

	assign cfg_ready = 1'b1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			org_x_q    <= '0;
			org_y_q    <= '0;
			org_z_q    <= '0;
			inv_cell_q <= 32'd65536;
			inv_time_q <= 32'd65536;
			dims_q     <= '0;
			tsteps_q   <= IDX_W'(1);
			ccount_q   <= CNT_W'(6);
		end else if (cfg_valid) begin
			case (cfg_index)
				REG_ORIGIN_X:   org_x_q    <= cfg_data;
				REG_ORIGIN_Y:   org_y_q    <= cfg_data;
				REG_ORIGIN_Z:   org_z_q    <= cfg_data;
				REG_INV_CELL:   inv_cell_q <= cfg_data;
				REG_INV_TIME:   inv_time_q <= cfg_data;
				REG_GRID_DIMS:  dims_q     <= cfg_data[29:0];
				REG_TIME_STEPS: tsteps_q   <= cfg_data[IDX_W-1:0];
				REG_COMP_COUNT: ccount_q   <= cfg_data[CNT_W-1:0];
				default: ;
			endcase
		end
	end

	// a count of zero acts as one, anything above the maximum as the maximum
	always_comb begin
		if (ccount_q == '0)
			cnt_clamped = CNT_W'(1);
		else if (ccount_q > CNT_W'(MAX_COMPONENTS))
			cnt_clamped = CNT_W'(MAX_COMPONENTS);
		else
			cnt_clamped = ccount_q;
	end

	always_comb begin
		cfg.origin_x   = org_x_q;
		cfg.origin_y   = org_y_q;
		cfg.origin_z   = org_z_q;
		cfg.inv_cell   = inv_cell_q;
		cfg.inv_time   = inv_time_q;
		cfg.nx         = dims_q[9:0];
		cfg.ny         = dims_q[19:10];
		cfg.nz         = dims_q[29:20];
		cfg.time_steps = tsteps_q;
		cfg.cnt        = cnt_clamped;
	end

	gfca_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg      (cfg),
		.in_valid (s_axis_tvalid),
		.in_ready (s_axis_tready),
		.in_op    (s_axis_tuser),
		.in_addr  (s_axis_tdata[15:0]),
		.in_value (s_axis_tdata[47:16]),
		.in_t     (s_axis_tdata[79:48]),
		.in_x     (s_axis_tdata[111:80]),
		.in_y     (s_axis_tdata[143:112]),
		.in_z     (s_axis_tdata[175:144]),
		.push     (push),
		.push_cmd (push_cmd),
		.q_full   (q_full)
	);

	gfca_queue u_queue (
		.clk      (clk),
		.arst_n   (arst_n),
		.push     (push),
		.push_cmd (push_cmd),
		.full     (q_full),
		.pop      (pop),
		.empty    (q_empty),
		.head     (head)
	);

	gfca_back u_back (
		.clk       (clk),
		.arst_n    (arst_n),
		.q_empty   (q_empty),
		.head      (head),
		.pop       (pop),
		.out_valid (m_axis_tvalid),
		.out_ready (m_axis_tready),
		.out_comp  (out_comp),
		.out_value (out_value),
		.out_last  (m_axis_tlast),
		.out_oob   (m_axis_tuser)
	);

	assign m_axis_tdata = {4'd0, out_value, out_comp};

`ifndef SYNTH
	// a miss beat carries nothing but the flag and tlast
	a_oob_beat: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tuser |->
		m_axis_tlast && (m_axis_tdata[35:0] == 36'd0))
		else $error("out-of-bounds beat with data or without tlast");

	// front takes one beat at a time
	a_one_beat: assert property (@(posedge clk) disable iff (!arst_n)
		s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
		else $error("front accepted a beat while busy");

	// nothing is pushed into a full queue
	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		q_full |-> !push || pop)
		else $error("command queue overflow");
`endif

endmodule

### verif/gfca_checker.sv
// Scoreboard for the grid field cell average gather unit, with shared grid helpers.
package gfca_tb_pkg;
	import gfca_pkg::*;

	typedef struct {
		logic signed [31:0] org_x;
		logic signed [31:0] org_y;
		logic signed [31:0] org_z;
		logic [31:0]        inv_cell;
		logic [31:0]        inv_time;
		logic [29:0]        dims;
		logic [10:0]        slabs;
		logic [4:0]         comps;
	} grid_setup_t;

	function automatic grid_setup_t setup_at_reset();
		grid_setup_t g;
		g.org_x = 0;
		g.org_y = 0;
		g.org_z = 0;
		g.inv_cell = 32'd65536;
		g.inv_time = 32'd65536;
		g.dims = '0;
		g.slabs = 11'd1;
		g.comps = 5'd6;
		return g;
	endfunction

	function automatic void apply_reg(ref grid_setup_t g, input logic [2:0] idx,
			input logic [31:0] d);
		case (idx)
			REG_ORIGIN_X: g.org_x = d;
			REG_ORIGIN_Y: g.org_y = d;
			REG_ORIGIN_Z: g.org_z = d;
			REG_INV_CELL: g.inv_cell = d;
			REG_INV_TIME: g.inv_time = d;
			REG_GRID_DIMS: g.dims = d[29:0];
			REG_TIME_STEPS: g.slabs = d[10:0];
			REG_COMP_COUNT: g.comps = d[4:0];
			default: ;
		endcase
	endfunction

	function automatic int clamp_comps(logic [4:0] c);
		if (c == 0)
			return 1;
		if (c > MAX_COMPONENTS)
			return MAX_COMPONENTS;
		return int'(c);
	endfunction

	// floor of (pos - org) * inv; a zero reciprocal pins the axis to cell 0
	function automatic bit axis_cell(logic signed [31:0] pos, logic signed [31:0] org,
			logic [31:0] inv, longint unsigned lim, output longint unsigned idx);
		longint d;
		logic [63:0] prod;
		d = longint'(pos) - longint'(org);
		if (d < 0) begin
			idx = 0;
			if (inv != 0)
				return 0;
		end else begin
			prod = 64'(d) * {32'd0, inv};
			idx = prod >> 32;
		end
		return idx < lim;
	endfunction

	function automatic bit locate(grid_setup_t g, logic signed [31:0] t,
			logic signed [31:0] x, logic signed [31:0] y, logic signed [31:0] z,
			output longint unsigned ti, output longint unsigned xi,
			output longint unsigned yi, output longint unsigned zi);
		longint unsigned nx, ny, nz;
		bit ok;
		nx = g.dims[9:0];
		ny = g.dims[19:10];
		nz = g.dims[29:20];
		ok = 1;
		ti = 0;
		if (g.slabs != 1)
			ok = axis_cell(t, 0, g.inv_time, g.slabs, ti) && ok;
		ok = axis_cell(x, g.org_x, g.inv_cell, nx ? nx - 1 : 0, xi) && ok;
		ok = axis_cell(y, g.org_y, g.inv_cell, ny ? ny - 1 : 0, yi) && ok;
		ok = axis_cell(z, g.org_z, g.inv_cell, nz ? nz - 1 : 0, zi) && ok;
		return ok;
	endfunction

	// corner bits: 2 steps x, 1 steps y, 0 steps z
	function automatic logic [15:0] corner_word(grid_setup_t g, longint unsigned ti,
			longint unsigned xi, longint unsigned yi, longint unsigned zi,
			int corner, int c);
		longint unsigned nx, ny, nz, node;
		nx = g.dims[9:0];
		ny = g.dims[19:10];
		nz = g.dims[29:20];
		node = ((ti * nz + zi + corner[0]) * ny + yi + corner[1]) * nx + xi + corner[2];
		return 16'(node * longint'(clamp_comps(g.comps)) + c);
	endfunction
endpackage

module gfca_checker import gfca_pkg::*; import gfca_tb_pkg::*; (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         cfg_valid,
	input  logic         cfg_ready,
	input  logic [2:0]   cfg_index,
	input  logic [31:0]  cfg_data,
	input  logic         s_axis_tvalid,
	input  logic         s_axis_tready,
	input  logic [175:0] s_axis_tdata,
	input  logic         s_axis_tuser,
	input  logic         m_axis_tvalid,
	input  logic         m_axis_tready,
	input  logic [39:0]  m_axis_tdata,
	input  logic         m_axis_tuser,
	input  logic         m_axis_tlast,
	output int           errors,
	output int           outstanding
);
	typedef struct {
		logic [3:0]  comp;
		logic [31:0] value;
		logic        last;
		logic        oob;
	} field_beat_t;

	grid_setup_t setup;
	logic [31:0] store [0:65535];
	field_beat_t averages_due[$];
	int shown;

	function automatic void predict_averages(logic [175:0] d);
		longint unsigned ti, xi, yi, zi;
		longint sum;
		logic [34:0] sum35;
		field_beat_t b;
		int n;
		if (!locate(setup, d[79:48], d[111:80], d[143:112], d[175:144], ti, xi, yi, zi)) begin
			b.comp = 0;
			b.value = 0;
			b.last = 1;
			b.oob = 1;
			averages_due.push_back(b);
			return;
		end
		n = clamp_comps(setup.comps);
		for (int c = 0; c < n; c++) begin
			sum = 0;
			for (int k = 0; k < 8; k++)
				sum += longint'($signed(store[corner_word(setup, ti, xi, yi, zi, k, c)]));
			sum35 = 35'(sum);
			b.comp = 4'(c);
			b.value = 32'($signed(sum35) >>> 3);	// floor of sum / 8
			b.last = (c == n - 1);
			b.oob = 0;
			averages_due.push_back(b);
		end
	endfunction

	always @(posedge clk or negedge arst_n) begin
		field_beat_t e;
		if (!arst_n) begin
			setup = setup_at_reset();
			averages_due.delete();
			errors = 0;
			shown = 0;
		end else begin
			if (m_axis_tvalid && m_axis_tready) begin
				if (averages_due.size() == 0) begin
					errors++;
					if (shown < 10) begin
						shown++;
						$display("mismatch: unexpected beat comp %0d value %h",
							m_axis_tdata[3:0], m_axis_tdata[35:4]);
					end
				end else begin
					e = averages_due.pop_front();
					if (m_axis_tdata[3:0] !== e.comp || m_axis_tdata[35:4] !== e.value ||
							m_axis_tdata[39:36] !== 4'd0 || m_axis_tlast !== e.last ||
							m_axis_tuser !== e.oob) begin
						errors++;
						if (shown < 10) begin
							shown++;
							$display("mismatch: exp comp %0d val %h last %b oob %b, got comp %0d val %h pad %h last %b oob %b",
								e.comp, e.value, e.last, e.oob, m_axis_tdata[3:0],
								m_axis_tdata[35:4], m_axis_tdata[39:36], m_axis_tlast,
								m_axis_tuser);
						end
					end
				end
			end
			if (cfg_valid && cfg_ready)
				apply_reg(setup, cfg_index, cfg_data);
			if (s_axis_tvalid && s_axis_tready) begin
				if (!s_axis_tuser)
					store[s_axis_tdata[15:0]] = s_axis_tdata[47:16];
				else
					predict_averages(s_axis_tdata);
			end
		end
		outstanding = averages_due.size();
	end
endmodule

### verif/grid_field_cell_average_gather_unit_test.sv
// Stimulus and verdict for the grid field cell average gather unit.
module grid_field_cell_average_gather_unit_test;
	import gfca_pkg::*;
	import gfca_tb_pkg::*;

	localparam int STALL_LIMIT = 4000;	// cycles with no beat anywhere
	localparam int DRAIN = 64;

	logic         clk;
	logic         arst_n;
	logic         cfg_valid;
	logic         cfg_ready;
	logic [2:0]   cfg_index;
	logic [31:0]  cfg_data;
	logic         s_axis_tvalid;
	logic         s_axis_tready;
	logic [175:0] s_axis_tdata;
	logic         s_axis_tuser;
	logic         m_axis_tvalid;
	logic         m_axis_tready;
	logic [39:0]  m_axis_tdata;
	logic         m_axis_tuser;
	logic         m_axis_tlast;
	int           errors;
	int           outstanding;

	grid_setup_t shadow;		// grid setup as the unit should now hold it
	bit written [0:65535];		// store words given a value so far
	bit calm;			// no idling on either side while set
	int n_writes, n_queries, n_setups, idle_cycles;

	grid_field_cell_average_gather_unit dut (.*);

	gfca_checker scoreboard (.*);

	initial clk = 0;
	always #4 clk = ~clk;

	// watchdog: any accepted beat on any channel counts as progress
	always @(posedge clk) begin
		if (arst_n) begin
			if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready) ||
					(cfg_valid && cfg_ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= STALL_LIMIT) begin
				$display("FAILED: results differ");
				$finish;
			end
		end
	end

	// result side: random stall before each beat
	initial begin
		int w;
		m_axis_tready = 0;
		@(posedge arst_n);
		@(negedge clk);
		forever begin
			w = calm ? 0 : $urandom_range(0, 18);
			if (w > 0) begin
				m_axis_tready = 0;
				repeat (w) @(negedge clk);
			end
			m_axis_tready = 1;
			@(posedge clk);
			while (!m_axis_tvalid) @(posedge clk);
			@(negedge clk);
		end
	end

	task automatic push_beat(input bit op, input logic [15:0] a, input logic [31:0] v,
			input logic [31:0] t, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z);
		int g;
		g = calm ? 0 : $urandom_range(0, 18);
		if (g > 0) begin
			s_axis_tvalid = 0;
			repeat (g) @(negedge clk);
		end
		s_axis_tuser = op;
		s_axis_tdata = {z, y, x, t, v, a};
		s_axis_tvalid = 1;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		@(negedge clk);
		if (op)
			n_queries++;
		else
			n_writes++;
	endtask

	task automatic store_word(input logic [15:0] a, input logic [31:0] v);
		push_beat(1'b0, a, v, $urandom, $urandom, $urandom, $urandom);
		written[a] = 1;
	endtask

	// fill: 0 fills only unwritten corners at random, 1 forces every corner
	// to fv, 2 puts fv on corner 0 and zero on the rest (rounding check)
	task automatic ask(input logic [31:0] t, input logic [31:0] x, input logic [31:0] y,
			input logic [31:0] z, input int fill = 0, input logic [31:0] fv = 0);
		longint unsigned ti, xi, yi, zi;
		logic [15:0] w;
		if (locate(shadow, t, x, y, z, ti, xi, yi, zi)) begin
			for (int c = 0; c < clamp_comps(shadow.comps); c++)
				for (int k = 0; k < 8; k++) begin
					w = corner_word(shadow, ti, xi, yi, zi, k, c);
					if (fill == 1)
						store_word(w, fv);
					else if (fill == 2)
						store_word(w, k == 0 ? fv : 32'd0);
					else if (!written[w])
						store_word(w, $urandom);
				end
		end
		push_beat(1'b1, $urandom, $urandom, t, x, y, z);
	endtask

	// distance in Q16.16 that covers the given number of cells
	function automatic int unsigned reach(longint unsigned cells, logic [31:0] inv);
		longint unsigned r;
		if (inv == 0)
			return 32'h40000;
		r = (cells << 32) / inv;
		return r > 64'h7FFF_FFFF ? 32'h7FFF_FFFF : 32'(r);
	endfunction

	task automatic random_query();
		longint unsigned nx, ny, nz;
		logic [31:0] t, x, y, z;
		nx = shadow.dims[9:0];
		ny = shadow.dims[19:10];
		nz = shadow.dims[29:20];
		if ($urandom_range(0, 3) == 0) begin
			t = $urandom;
			x = $urandom;
			y = $urandom;
			z = $urandom;
		end else begin
			t = $urandom_range(0, reach(shadow.slabs, shadow.inv_time));
			x = shadow.org_x + $urandom_range(0, reach(nx ? nx - 1 : 0, shadow.inv_cell));
			y = shadow.org_y + $urandom_range(0, reach(ny ? ny - 1 : 0, shadow.inv_cell));
			z = shadow.org_z + $urandom_range(0, reach(nz ? nz - 1 : 0, shadow.inv_cell));
		end
		ask(t, x, y, z);
	endtask

	task automatic random_run(input int n);
		repeat (n) begin
			if ($urandom_range(0, 4) == 0)
				store_word($urandom, $urandom);
			else
				random_query();
		end
	endtask

	task automatic set_reg(input logic [2:0] idx, input logic [31:0] d);
		cfg_index = idx;
		cfg_data = d;
		cfg_valid = 1;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		@(negedge clk);
		cfg_valid = 0;
		apply_reg(shadow, idx, d);
	endtask

	function automatic logic [31:0] pack_dims(int nx, int ny, int nz);
		return {2'b00, 10'(nz), 10'(ny), 10'(nx)};
	endfunction

	// registers only move once every average is out and the front end is quiet
	task automatic configure(input logic [31:0] ox, input logic [31:0] oy,
			input logic [31:0] oz, input logic [31:0] ic, input logic [31:0] it,
			input logic [31:0] dims, input logic [31:0] ts, input logic [31:0] cnt);
		s_axis_tvalid = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		set_reg(REG_ORIGIN_X, ox);
		set_reg(REG_ORIGIN_Y, oy);
		set_reg(REG_ORIGIN_Z, oz);
		set_reg(REG_INV_CELL, ic);
		set_reg(REG_INV_TIME, it);
		set_reg(REG_GRID_DIMS, dims);
		set_reg(REG_TIME_STEPS, ts);
		set_reg(REG_COMP_COUNT, cnt);
		n_setups++;
	endtask

	initial begin
		arst_n = 0;
		cfg_valid = 0;
		cfg_index = REG_ORIGIN_X;
		cfg_data = 0;
		s_axis_tvalid = 0;
		s_axis_tdata = '0;
		s_axis_tuser = 0;
		calm = 0;
		idle_cycles = 0;
		shadow = setup_at_reset();
		repeat (8) @(negedge clk);
		arst_n = 1;

		// reset setup has no grid, so every query is a miss
		store_word(16'h0000, 32'h7FFF_FFFF);
		store_word(16'hFFFF, 32'h8000_0000);
		ask(0, 0, 0, 0);
		ask(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF);
		ask(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000);
		random_run(8);

		// 3x3x3 static grid, unit cells, six components
		configure(0, 0, 0, 32'd65536, 32'd65536, pack_dims(3, 3, 3), 1, 6);
		ask(0, 0, 0, 0, 1, 32'h7FFF_FFFF);		// largest corner sum
		ask(32'h8000_0000, 32'h1FFFF, 32'h1FFFF, 32'h1FFFF, 1, 32'h8000_0000);
		ask(32'h7FFF_FFFF, 32'h18000, 0, 32'h10000, 2, 32'hFFFF_FFFF);	// -1/8 floors to -1
		ask(0, 32'h20000, 0, 0);			// upper edge is a miss
		ask(0, 32'hFFFF_FFFF, 0, 0);			// just below origin
		ask(0, 0, 32'h20000, 32'h8000_0000);
		random_run(20);

		// zero cell reciprocal, extreme origins, two slabs, full component count
		calm = 1;
		configure(32'h8000_0000, 32'h7FFF_FFFF, 32'h0010_0000, 32'd0, 32'd32768,
			pack_dims(2, 2, 2), 2, 16);
		ask(0, 32'h7FFF_FFFF, 32'h8000_0000, 0);
		ask(32'h3FFFF, 0, 0, 0);
		ask(32'h40000, 0, 0, 0);			// past the last slab
		ask(32'hFFFF_FFFF, 0, 0, 0);			// negative time
		random_run(20);
		calm = 0;

		// largest grid and reciprocal, zero time reciprocal, count of 0
		configure(32'h0001_2345, 32'hFFFE_0000, 0, 32'hFFFF_FFFF, 32'd0,
			pack_dims(1023, 1023, 1023), 1024, 0);
		random_run(20);

		// no time slabs at all, count above the maximum
		configure(32'h0002_0000, 0, 32'hFFFF_0000, 32'd131072, 32'hFFFF_FFFF,
			pack_dims(4, 3, 5), 0, 31);
		random_run(8);

		repeat (2) begin
			configure(($urandom_range(0, 3) == 0) ? $urandom : $urandom_range(0, 32'h40000) - 32'h20000,
				$urandom_range(0, 32'h40000) - 32'h20000,
				$urandom_range(0, 32'h40000) - 32'h20000,
				($urandom_range(0, 3) == 0) ? $urandom : 32'd16384 << $urandom_range(0, 3),
				32'd16384 << $urandom_range(0, 3),
				pack_dims($urandom_range(0, 6), $urandom_range(0, 6), $urandom_range(0, 6)),
				$urandom_range(1, 3), $urandom_range(0, 31));
			random_run(20);
		end

		s_axis_tvalid = 0;
		while (outstanding != 0) @(negedge clk);
		repeat (DRAIN) @(negedge clk);
		$display("Ran %0d store writes and %0d queries across %0d grid setups,",
			n_writes, n_queries, n_setups);
		$display("including empty grids, zero reciprocals and clamped counts.");
		if (errors == 0)
			$display("PASSED: all results match");
		else
			$display("FAILED: results differ");
		$finish;
	end
endmodule

### files.f
sv/gfca_pkg.sv
sv/gfca_front.sv
sv/gfca_queue.sv
sv/gfca_back.sv
sv/grid_field_cell_average_gather_unit.sv
verif/gfca_checker.sv
verif/grid_field_cell_average_gather_unit_test.sv
